### rtl/wsdf_pkg.sv
`timescale 1ns / 1ps

package wsdf_pkg;

    // Widths of the stream byte and the configuration register
    localparam int unsigned ByteW  = 8;
    localparam int unsigned LimitW = 16;

    // Frame opcodes of interest
    localparam logic [3:0] OpCont  = 4'h0;
    localparam logic [3:0] OpText  = 4'h1;
    localparam logic [3:0] OpClose = 4'h8;
    localparam logic [3:0] OpPing  = 4'h9;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] Len7Ext16 = 7'd126;
    localparam logic [6:0] Len7Ext64 = 7'd127;

    // Most ping payload bytes passed on per frame
    localparam logic [LimitW-1:0] PingMax = 16'd125;

    // Reset value of the text limit register
    localparam logic [LimitW-1:0] MaxTextReset = 16'hFFFF;

    // Kinds of result beat
    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_PING  = 2'd1,
        KIND_EPING = 2'd2,
        KIND_CLOSE = 2'd3
    } kind_t;

    // One result beat
    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] data;
        logic             last;
    } evt_t;

endpackage

### rtl/wsdf_byte_if.sv
`timescale 1ns / 1ps

interface wsdf_byte_if;
    import wsdf_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/wsdf_evt_if.sv
`timescale 1ns / 1ps

interface wsdf_evt_if;
    import wsdf_pkg::*;

    logic             valid;
    logic             ready;
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic             last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

### rtl/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps

// Channel   | Dir | Payload                 | Beat moves
// ----------+-----+-------------------------+-------------------------------
// rx        | in  | rx_byte[7:0]            | one byte of the received stream
// ev        | out | kind[1:0] data[7:0] last| one text/ping byte or event
// cfg       | in  | cfg_we, cfg_wdata[15:0] | write of max_text_len
//
// Each accepted byte is parsed in the cycle it arrives; its result, if any, is
// registered in the output register, or in the one-beat skid stage behind it
// while ev has not taken the output beat. One byte per cycle sustained while rx
// is not stalled; it stalls only when both hold a beat. rst_n clears the parser
// state and output beats, sets max_text_len to 65535; there is no clearing pass.

module websocket_frame_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wsdf_pkg::LimitW-1:0]   cfg_wdata,
    wsdf_byte_if.sink                     rx,
    wsdf_evt_if.source                    ev
);
    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    // Parser state
    phase_t             phase_reg,   phase_next;
    logic [3:0]         opcode_reg,  opcode_next;
    logic               mask_reg,    mask_next;
    logic [3:0]         cnt_reg,     cnt_next;
    logic [63:0]        plen_reg,    plen_next;
    logic [31:0]        key_reg,     key_next;
    logic [63:0]        pidx_reg,    pidx_next;
    logic               closed_reg,  closed_next;
    logic [LimitW-1:0]  max_text_reg;

    // Output register and skid stage
    logic               out_valid_reg, skid_valid_reg;
    evt_t               out_reg, skid_reg;

    // Per-byte result
    logic               res_valid;
    evt_t               res;

    logic               accept;
    logic               hdr_done;
    logic [63:0]        hdr_len;
    logic               len_done;
    logic [63:0]        len_val;
    logic [LimitW-1:0]  limit;
    kind_t              pay_kind;
    logic [63:0]        end_len;
    logic [63:0]        idx_inc;
    logic [ByteW-1:0]   key_byte;

    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;

    assign ev.valid = out_valid_reg;
    assign ev.kind  = out_reg.kind;
    assign ev.data  = out_reg.data;
    assign ev.last  = out_reg.last;

    // Work out the next parser state and the result for this byte
    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        cnt_next    = cnt_reg;
        plen_next   = plen_reg;
        key_next    = key_reg;
        pidx_next   = pidx_reg;
        closed_next = closed_reg;
        res_valid   = 1'b0;
        res         = '{kind: KIND_TEXT, data: '0, last: 1'b0};
        hdr_done    = 1'b0;
        hdr_len     = plen_reg;
        len_done    = 1'b0;
        len_val     = plen_reg;
        limit       = '0;
        pay_kind    = KIND_TEXT;
        end_len     = '0;
        idx_inc     = pidx_reg + 64'd1;
        key_byte    = '0;

        if (!closed_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = rx.rx_byte[7];
                    cnt_next  = '0;
                    plen_next = '0;
                    if (rx.rx_byte[6:0] == Len7Ext16)
                    begin
                        phase_next = PH_EXT16;
                    end
                    else if (rx.rx_byte[6:0] == Len7Ext64)
                    begin
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        plen_next = {57'd0, rx.rx_byte[6:0]};
                        len_done  = 1'b1;
                        len_val   = {57'd0, rx.rx_byte[6:0]};
                        mask_next = rx.rx_byte[7];
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    plen_next = {plen_reg[55:0], rx.rx_byte};
                    cnt_next  = cnt_reg + 4'd1;
                    if (cnt_next == ((phase_reg == PH_EXT16) ? 4'd2 : 4'd8))
                    begin
                        len_done = 1'b1;
                        len_val  = {plen_reg[55:0], rx.rx_byte};
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx.rx_byte};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next == 4'd4)
                    begin
                        hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    // Pick the per-frame limit and kind from the opcode
                    if (opcode_reg == OpPing)
                    begin
                        limit    = PingMax;
                        pay_kind = KIND_PING;
                    end
                    else if (opcode_reg == OpText || opcode_reg == OpCont)
                    begin
                        limit = max_text_reg;
                    end
                    end_len = (plen_reg < {48'd0, limit}) ? plen_reg : {48'd0, limit};
                    unique case (pidx_reg[1:0])
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                    if (!mask_reg)
                    begin
                        key_byte = '0;
                    end
                    if ((pidx_reg[63:16] == '0) && (pidx_reg[15:0] < limit))
                    begin
                        res_valid = 1'b1;
                        res.kind  = pay_kind;
                        res.data  = rx.rx_byte ^ key_byte;
                        res.last  = (idx_inc == end_len);
                    end
                    pidx_next = idx_inc;
                    if (idx_inc == plen_reg)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    opcode_next = rx.rx_byte[3:0];
                    mask_next   = 1'b0;
                    key_next    = '0;
                    phase_next  = PH_HDR1;
                end
            endcase

            // Length complete: go for the mask key or finish the header
            if (len_done)
            begin
                cnt_next = '0;
                if (mask_next)
                begin
                    phase_next = PH_MASK;
                end
                else
                begin
                    hdr_done = 1'b1;
                    hdr_len  = len_val;
                end
            end

            // Header done: raise close or empty ping, skip empty, else payload
            if (hdr_done)
            begin
                pidx_next = '0;
                if (opcode_reg == OpClose)
                begin
                    closed_next = 1'b1;
                    phase_next  = PH_HDR0;
                    res_valid   = 1'b1;
                    res         = '{kind: KIND_CLOSE, data: '0, last: 1'b1};
                end
                else if (hdr_len == '0)
                begin
                    phase_next = PH_HDR0;
                    if (opcode_reg == OpPing)
                    begin
                        res_valid = 1'b1;
                        res       = '{kind: KIND_EPING, data: '0, last: 1'b1};
                    end
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    // Hold parser state, the limit register and the output beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            opcode_reg     <= '0;
            mask_reg       <= 1'b0;
            cnt_reg        <= '0;
            plen_reg       <= '0;
            key_reg        <= '0;
            pidx_reg       <= '0;
            closed_reg     <= 1'b0;
            max_text_reg   <= MaxTextReset;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_text_reg <= cfg_wdata;
            end

            // Advance the parser on each accepted byte
            if (accept)
            begin
                phase_reg  <= phase_next;
                opcode_reg <= opcode_next;
                mask_reg   <= mask_next;
                cnt_reg    <= cnt_next;
                plen_reg   <= plen_next;
                key_reg    <= key_next;
                pidx_reg   <= pidx_next;
                closed_reg <= closed_next;
            end

            // Refill the output register, or park the result in the skid stage
            if (ev.ready || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept && res_valid;
                    out_reg       <= res;
                end
            end
            else if (accept && res_valid)
            begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= res;
            end
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wsdf_pkg::*;

    localparam int PLAN_LEN    = 31;
    localparam int FEED_BYTES  = 1100;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    // Parser phases of the frame predictor
    typedef enum logic [2:0] {
        P_HEAD0,
        P_HEAD1,
        P_LEN16,
        P_LEN64,
        P_KEY,
        P_BODY
    } parse_t;

    // One line of the directed plan: a limit write or a stream byte
    typedef struct {
        logic        is_cfg;
        logic [15:0] limit;
        logic [7:0]  b;
        logic        typed;
        logic        hit;
        evt_t        res;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [LimitW-1:0] cfg_wdata;

    wsdf_byte_if rx_if ();
    wsdf_evt_if  ev_if ();

    websocket_frame_deframer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_if),
        .ev        (ev_if)
    );

    always #5 clk = ~clk;

    // Predictor state, mirrors the parser
    parse_t            m_phase  = P_HEAD0;
    logic [3:0]        m_op     = 4'h0;
    logic              m_masked = 1'b0;
    logic [3:0]        m_cnt    = 4'h0;
    logic [63:0]       m_len    = '0;
    logic [31:0]       m_key    = '0;
    logic [63:0]       m_idx    = '0;
    logic              m_closed = 1'b0;
    logic [LimitW-1:0] m_limit  = MaxTextReset;

    evt_t      pending_evts[$];
    plan_row_t plan[PLAN_LEN];
    evt_t      want;

    int errors     = 0;
    int n_fed      = 0;
    int n_frames   = 0;
    int n_limits   = 0;
    int n_beats    = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int stall      = 0;
    logic tx_calm  = 1'b0;

    // Frame header is complete: decide between event, skip and payload
    function automatic void header_complete(output logic hit, output evt_t res);
        hit = 1'b0;
        res = '0;
        m_idx = '0;
        if (m_op == OpClose) begin
            m_closed = 1'b1;
            m_phase  = P_HEAD0;
            hit      = 1'b1;
            res.kind = KIND_CLOSE;
            res.last = 1'b1;
        end
        else if (m_len == 0) begin
            m_phase = P_HEAD0;
            if (m_op == OpPing) begin
                hit      = 1'b1;
                res.kind = KIND_EPING;
                res.last = 1'b1;
            end
        end
        else begin
            m_phase = P_BODY;
        end
    endfunction

    // Length known: go on to the mask key or finish the header
    function automatic void length_complete(output logic hit, output evt_t res);
        hit = 1'b0;
        res = '0;
        m_cnt = '0;
        if (m_masked)
            m_phase = P_KEY;
        else
            header_complete(hit, res);
    endfunction

    // Advance the predictor by one stream byte
    function automatic void deframe(input logic [7:0] b, output logic hit,
                                    output evt_t res);
        logic [63:0] cap;
        logic [63:0] stop_at;
        logic [7:0]  k;
        hit = 1'b0;
        res = '0;
        if (m_closed)
            return;
        case (m_phase)
            P_HEAD1:
            begin
                m_masked = b[7];
                m_len    = '0;
                m_cnt    = '0;
                if (b[6:0] == Len7Ext16)
                    m_phase = P_LEN16;
                else if (b[6:0] == Len7Ext64)
                    m_phase = P_LEN64;
                else
                begin
                    m_len = {57'd0, b[6:0]};
                    length_complete(hit, res);
                end
            end
            P_LEN16, P_LEN64:
            begin
                m_len = {m_len[55:0], b};
                m_cnt = m_cnt + 4'd1;
                if (m_cnt == ((m_phase == P_LEN16) ? 4'd2 : 4'd8))
                    length_complete(hit, res);
            end
            P_KEY:
            begin
                m_key = {m_key[23:0], b};
                m_cnt = m_cnt + 4'd1;
                if (m_cnt == 4'd4)
                    header_complete(hit, res);
            end
            P_BODY:
            begin
                res.kind = KIND_TEXT;
                if (m_op == OpPing)
                begin
                    cap      = {48'd0, PingMax};
                    res.kind = KIND_PING;
                end
                else if (m_op == OpText || m_op == OpCont)
                    cap = {48'd0, m_limit};
                else
                    cap = '0;
                if (m_idx < cap)
                begin
                    stop_at  = (m_len < cap) ? m_len : cap;
                    k        = m_masked ? m_key[8 * (3 - m_idx[1:0]) +: 8] : 8'h00;
                    hit      = 1'b1;
                    res.data = b ^ k;
                    res.last = (m_idx + 1 == stop_at);
                end
                m_idx = m_idx + 1;
                if (m_idx == m_len)
                    m_phase = P_HEAD0;
            end
            default:
            begin
                m_op     = b[3:0];
                m_masked = 1'b0;
                m_key    = '0;
                m_phase  = P_HEAD1;
            end
        endcase
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic plan_row_t row_b(input logic [7:0] b);
        return '{1'b0, 16'h0, b, 1'b0, 1'b0, evt_t'('0)};
    endfunction

    function automatic plan_row_t row_n(input logic [7:0] b);
        return '{1'b0, 16'h0, b, 1'b1, 1'b0, evt_t'('0)};
    endfunction

    function automatic plan_row_t row_t(input logic [7:0] b, input kind_t kd,
                                        input logic [7:0] d, input logic l);
        evt_t e;
        e.kind = kd;
        e.data = d;
        e.last = l;
        return '{1'b0, 16'h0, b, 1'b1, 1'b1, e};
    endfunction

    function automatic plan_row_t row_c(input logic [15:0] v);
        return '{1'b1, v, 8'h00, 1'b0, 1'b0, evt_t'('0)};
    endfunction

    // Offer one byte, wait for the beat, then book its expected result
    task automatic feed(input logic [7:0] b, input logic typed = 1'b0,
                        input logic t_hit = 1'b0, input evt_t t_res = '0);
        int   gap;
        logic hit;
        evt_t res;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        deframe(b, hit, res);
        if (typed)
        begin
            hit = t_hit;
            res = t_res;
        end
        if (hit)
            pending_evts.push_back(res);
        n_fed++;
    endtask

    // Drain the block, then write the text limit
    task automatic set_limit(input logic [15:0] v);
        rx_if.valid <= 1'b0;
        while (pending_evts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_limit = v;
        n_limits++;
    endtask

    // Send a whole frame with random flags, key and payload
    task automatic send_frame(input logic [3:0] op, input logic masked,
                              input int unsigned len, input int form);
        logic [63:0] len64;
        logic [3:0]  flags;
        len64 = len;
        flags = 4'($urandom_range(0, 15));
        feed({flags, op});
        case (form)
            0: feed({masked, len64[6:0]});
            1:
            begin
                feed({masked, Len7Ext16});
                feed(len64[15:8]);
                feed(len64[7:0]);
            end
            default:
            begin
                feed({masked, Len7Ext64});
                for (int i = 7; i >= 0; i--)
                    feed(len64[8 * i +: 8]);
            end
        endcase
        if (masked)
            repeat (4) feed(rand_byte());
        repeat (len) feed(rand_byte());
        n_frames++;
    endtask

    // Check each delivered beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && ev_if.valid && ev_if.ready)
        begin
            n_beats++;
            if (pending_evts.size() == 0)
            begin
                $display("%0t: unexpected beat kind %0d data %02h last %0b", $time,
                         ev_if.kind, ev_if.data, ev_if.last);
                errors++;
            end
            else
            begin
                want = pending_evts.pop_front();
                kind_seen[want.kind]++;
                if (ev_if.kind !== want.kind || ev_if.data !== want.data ||
                    ev_if.last !== want.last)
                begin
                    $display({"%0t: mismatch expected kind %0d data %02h last %0b,",
                              " got kind %0d data %02h last %0b"},
                             $time, want.kind, want.data, want.last,
                             ev_if.kind, ev_if.data, ev_if.last);
                    errors++;
                end
            end
        end
    end

    // Abort when neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready))
                stall <= 0;
            else
                stall <= stall + 1;
            if (stall >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_evts.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, one long hold-off to fill the block
    initial
    begin
        int  gap;
        int  run;
        logic held;
        held = 1'b0;
        ev_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && n_beats >= 100)
            begin
                held = 1'b1;
                ev_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = idle_len();
                if (gap > 0)
                begin
                    ev_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                               : $urandom_range(20, 100);
            ev_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    // Stream side: directed plan, random frames, closing frame
    initial
    begin
        int          r;
        int          form;
        int unsigned len;
        logic [3:0]  op;
        logic        masked;
        int          fr;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;

        plan = '{
            // unmasked text, limit cut mid-frame
            row_c(16'hFFFF), row_b(8'h81), row_b(8'h03), row_t(8'h00, KIND_TEXT, 8'h00, 1'b0),
            row_c(16'h0001), row_n(8'hFF), row_n(8'h12),
            // masked one-byte ping
            row_b(8'h89), row_b(8'h81), row_b(8'hA5), row_b(8'h5A), row_b(8'hFF),
            row_b(8'h00), row_b(8'h5A),
            // empty ping, empty text
            row_b(8'h89), row_t(8'h00, KIND_EPING, 8'h00, 1'b1),
            row_b(8'h01), row_n(8'h00),
            // unknown opcode with RSV bits, continuation under a zero limit
            row_c(16'h0000), row_b(8'hF2), row_b(8'h01), row_n(8'h33),
            row_b(8'h80), row_b(8'h01), row_n(8'h44),
            // 16-bit extended length
            row_c(16'hFFFF), row_b(8'h81), row_b(8'h7E), row_b(8'h00), row_b(8'h01),
            row_t(8'h7F, KIND_TEXT, 8'h7F, 1'b1)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan; it ends on a frame boundary
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].is_cfg)
                set_limit(plan[i].limit);
            else
                feed(plan[i].b, plan[i].typed, plan[i].hit, plan[i].res);
        end

        // Random well-formed frames with random flags and content
        fr = 0;
        while (n_fed < PLAN_LEN + FEED_BYTES)
        begin
            if (fr % 6 == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    set_limit(16'h0000);
                else if (r < 20)
                    set_limit(16'h0001);
                else if (r < 55)
                    set_limit(16'($urandom_range(2, 20)));
                else if (r < 80)
                    set_limit(16'hFFFF);
                else
                    set_limit(16'($urandom_range(1, 65535)));
            end
            fr++;
            tx_calm = ($urandom_range(0, 3) == 0);

            r = $urandom_range(0, 99);
            if (r < 40)
                op = OpText;
            else if (r < 55)
                op = OpCont;
            else if (r < 75)
                op = OpPing;
            else
            begin
                op = 4'($urandom_range(2, 15));
                if (op == OpClose || op == OpPing)
                    op = 4'hA;
            end

            r = $urandom_range(0, 99);
            if (r < 15)
                len = 0;
            else if (r < 80)
                len = $urandom_range(1, 12);
            else if (r < 93)
                len = $urandom_range(13, 60);
            else if (r < 97)
                len = $urandom_range(120, 140);
            else
                len = $urandom_range(200, 300);

            r = $urandom_range(0, 99);
            if (len > 125)
                form = (r < 50) ? 1 : 2;
            else
                form = (r < 75) ? 0 : ((r < 90) ? 1 : 2);
            masked = $urandom_range(0, 1);
            send_frame(op, masked, len, form);
        end

        // Close with payload; everything after it is ignored
        tx_calm = 1'b0;
        send_frame(OpClose, 1'b1, 5, 0);
        repeat (6) feed(rand_byte());

        rx_if.valid <= 1'b0;
        while (pending_evts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Fed %0d stream bytes in %0d random frames under %0d limit settings",
                 n_fed, n_frames, n_limits);
        $display("Checked %0d text, %0d ping, %0d empty ping and %0d close beats",
                 kind_seen[KIND_TEXT], kind_seen[KIND_PING], kind_seen[KIND_EPING],
                 kind_seen[KIND_CLOSE]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
